### hdl/pts_pkg.sv
package pts_pkg;

   // Operation codes carried in req_tuser
   typedef enum logic [1:0] {
      OP_CREATE   = 2'd0,
      OP_DELETE   = 2'd1,
      OP_TICK     = 2'd2,
      OP_DISPATCH = 2'd3
   } op_type;

   // Per-slot lifecycle
   typedef enum logic [1:0] {
      ST_DELETED = 2'd0,
      ST_WAITING = 2'd1,
      ST_READY   = 2'd2
   } slot_state_type;

   // Fixed field widths of the stream payload
   localparam int SLOT_W   = 3;
   localparam int PERIOD_W = 16;
   localparam int MASK_W   = 8;

   // Command broadcast to every slot for one accepted transaction
   typedef struct packed {
      logic   accept;   // transaction accepted this cycle
      op_type op;       // operation of the transaction
      logic   sel;      // create/delete addresses this slot
      logic   pick;     // dispatch chose this slot
   } slot_cmd_type;

   // Outcome of the lowest-ready search
   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] index;
   } pick_result_type;

endpackage

### hdl/pts_slot.sv
module pts_slot #(
   parameter int PERIOD_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pts_pkg::slot_cmd_type   cmd,
   input  logic [PERIOD_BITS-1:0]  period,      // already masked, zero mapped to one
   output logic                    ready_now,
   output logic                    ready_next
);
   import pts_pkg::*;

   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic [PERIOD_BITS-1:0] count_ff, count_in;
   slot_state_type         state_ff, state_in;
   logic [PERIOD_BITS-1:0] count_dec;

   assign count_dec = count_ff - PERIOD_BITS'(1);

   // Slot update for the accepted transaction
   always_comb begin
      period_in = period_ff;
      count_in  = count_ff;
      state_in  = state_ff;
      if (cmd.accept) begin
         unique case (cmd.op)
            OP_CREATE: begin
               if (cmd.sel) begin
                  period_in = period;
                  count_in  = period;
                  state_in  = ST_READY;
               end
            end
            OP_DELETE: begin
               if (cmd.sel) begin
                  period_in = '0;
                  count_in  = '0;
                  state_in  = ST_DELETED;
               end
            end
            OP_TICK: begin
               if (state_ff != ST_DELETED) begin
                  if (count_dec == '0) begin
                     // expiry: reload, ready stays ready (overrun dropped)
                     count_in = period_ff;
                     state_in = ST_READY;
                  end else begin
                     count_in = count_dec;
                  end
               end
            end
            OP_DISPATCH: begin
               if (cmd.pick) begin
                  state_in = ST_WAITING;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
         count_ff  <= '0;
         state_ff  <= ST_DELETED;
      end else begin
         period_ff <= period_in;
         count_ff  <= count_in;
         state_ff  <= state_in;
      end
   end

   assign ready_now  = (state_ff == ST_READY);
   assign ready_next = (state_in == ST_READY);

endmodule

### hdl/pts_pick.sv
module pts_pick #(
   parameter int NUM_TASKS = 8
) (
   input  logic [NUM_TASKS-1:0]     ready,
   output logic [NUM_TASKS-1:0]     onehot,
   output pts_pkg::pick_result_type result
);
   import pts_pkg::*;

   logic [SLOT_W-1:0] index;

   // Isolate the lowest set bit: highest priority ready slot
   assign onehot = ready & (~ready + NUM_TASKS'(1));

   // Encode the one-hot pick, low three bits of the slot number
   always_comb begin
      index = '0;
      for (int s = 0; s < NUM_TASKS; s++) begin
         if (onehot[s]) begin
            index = index | SLOT_W'(s);
         end
      end
   end

   assign result.found = |ready;
   assign result.index = index;

endmodule

### hdl/periodic_task_scheduler_top.sv
// Channel | Dir | tuser              | tdata (low bit up)
// req     | in  | [1:0] operation    | [2:0] task_slot, [18:3] period_ticks
// rsp     | out | [0] dispatch_valid | [2:0] dispatch_index, [10:3] ready_mask
//
// One transaction per cycle; its response appears in the output register
// the cycle after acceptance. All slots update in parallel in the same edge.
// The output register is the only buffer: req_tready drops while a response
// waits and rsp_tready is low. Reset (synchronous) deletes every slot.
module periodic_task_scheduler_top #(
   parameter int NUM_TASKS   = 8,
   parameter int PERIOD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,    // [1:0] operation
   input  logic [23:0] req_tdata,    // [2:0] task_slot, [18:3] period_ticks
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [0:0]  rsp_tuser,    // [0] dispatch_valid
   output logic [15:0] rsp_tdata     // [2:0] dispatch_index, [10:3] ready_mask
);
   import pts_pkg::*;

   logic                        accept;
   op_type                      op;
   logic [SLOT_W-1:0]           slot;
   logic [PERIOD_W-1:0]         period_raw;
   logic [PERIOD_BITS+PERIOD_W-1:0] period_wide;
   logic [PERIOD_BITS-1:0]      period_mask;
   logic [PERIOD_BITS-1:0]      period_eff;
   logic [NUM_TASKS-1:0]        ready_now;
   logic [NUM_TASKS-1:0]        ready_next;
   logic [NUM_TASKS-1:0]        pick_onehot;
   pick_result_type             pick;
   logic [MASK_W-1:0]           mask;
   logic                        disp_valid;
   logic [SLOT_W-1:0]           disp_index;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [0:0]                  rsp_user_ff, rsp_user_in;
   logic [15:0]                 rsp_data_ff, rsp_data_in;

   // Unpack the request
   assign accept     = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);
   assign slot       = req_tdata[2:0];
   assign period_raw = req_tdata[18:3];

   // Fit the period to PERIOD_BITS, zero taken as one
   assign period_wide = {PERIOD_BITS'(0), period_raw};
   assign period_mask = period_wide[PERIOD_BITS-1:0];
   assign period_eff  = (period_mask == '0) ? PERIOD_BITS'(1) : period_mask;

   pts_pick #(
      .NUM_TASKS(NUM_TASKS)
   ) u_pick (
      .ready (ready_now),
      .onehot(pick_onehot),
      .result(pick)
   );

   // Row of task slots
   for (genvar s = 0; s < NUM_TASKS; s++) begin : g_slot
      slot_cmd_type cmd;
      assign cmd.accept = accept;
      assign cmd.op     = op;
      assign cmd.sel    = (32'(slot) == s);
      assign cmd.pick   = pick_onehot[s];

      pts_slot #(
         .PERIOD_BITS(PERIOD_BITS)
      ) u_slot (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .period    (period_eff),
         .ready_now (ready_now[s]),
         .ready_next(ready_next[s])
      );
   end

   // Ready mask shows the first eight slots only
   for (genvar b = 0; b < MASK_W; b++) begin : g_mask
      if (b < NUM_TASKS) begin : g_on
         assign mask[b] = ready_next[b];
      end else begin : g_off
         assign mask[b] = 1'b0;
      end
   end

   assign disp_valid = (op == OP_DISPATCH) && pick.found;
   assign disp_index = disp_valid ? pick.index : '0;

   // Output register
   assign req_tready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = disp_valid;
         rsp_data_in  = {5'd0, mask, disp_index};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Assertions
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while response stalled");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted transaction produced no response");

   a_pick_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(pick_onehot) && (pick.found == (pick_onehot != '0)))
      else $error("dispatch pick not one-hot or inconsistent");

   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[2:0] == 3'd0))
      else $error("index nonzero without dispatch");

endmodule

### bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pts_pkg::*;

   localparam int TASK_SLOTS   = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;

   // Expected response of one request transaction
   typedef struct {
      logic              valid;
      logic [SLOT_W-1:0] index;
      logic [MASK_W-1:0] mask;
   } dispatch_result_type;

   // Shadow task table plus queue of dispatch results still owed by the block
   class sched_scoreboard;
      logic [PERIOD_W-1:0] period_tab [TASK_SLOTS];
      logic [PERIOD_W-1:0] count_left [TASK_SLOTS];
      slot_state_type      life       [TASK_SLOTS];
      dispatch_result_type pending_results[$];
      int                  mismatches;
      int                  responses;
      int                  hits;
      int                  op_count[4];

      function new();
         foreach (life[s]) begin
            period_tab[s] = '0;
            count_left[s] = '0;
            life[s]       = ST_DELETED;
         end
         mismatches = 0;
         responses  = 0;
         hits       = 0;
         foreach (op_count[k]) op_count[k] = 0;
      endfunction

      // Apply one accepted request to the shadow table and queue its response
      function void note_request(op_type op, logic [SLOT_W-1:0] slot,
                                 logic [PERIOD_W-1:0] per);
         dispatch_result_type res;
         res.valid = 1'b0;
         res.index = '0;
         res.mask  = '0;
         op_count[int'(op)]++;
         case (op)
            OP_CREATE: begin
               // a zero period counts as one, as in the design
               period_tab[slot] = (per == '0) ? PERIOD_W'(1) : per;
               count_left[slot] = period_tab[slot];
               life[slot]       = ST_READY;
            end
            OP_DELETE: begin
               period_tab[slot] = '0;
               count_left[slot] = '0;
               life[slot]       = ST_DELETED;
            end
            OP_TICK: begin
               for (int s = 0; s < TASK_SLOTS; s++) begin
                  if (life[s] != ST_DELETED) begin
                     count_left[s] = count_left[s] - 1'b1;
                     // expiry: reload; a slot already ready just stays ready
                     if (count_left[s] == '0) begin
                        life[s]       = ST_READY;
                        count_left[s] = period_tab[s];
                     end
                  end
               end
            end
            default: begin
               // lowest index wins
               for (int s = 0; s < TASK_SLOTS; s++) begin
                  if (!res.valid && life[s] == ST_READY) begin
                     life[s]   = ST_WAITING;
                     res.valid = 1'b1;
                     res.index = SLOT_W'(s);
                  end
               end
               if (res.valid) hits++;
            end
         endcase
         for (int s = 0; s < TASK_SLOTS && s < MASK_W; s++)
            res.mask[s] = (life[s] == ST_READY);
         pending_results.push_back(res);
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] MISMATCH: %s", $time, msg);
         mismatches++;
      endtask

      // Compare one accepted response with the oldest expectation
      task check_response(logic valid, logic [SLOT_W-1:0] index, logic [MASK_W-1:0] mask);
         dispatch_result_type want;
         responses++;
         if (pending_results.size() == 0) begin
            report_mismatch("response transaction with no request outstanding");
            return;
         end
         want = pending_results.pop_front();
         if (valid !== want.valid)
            report_mismatch($sformatf("dispatch_valid got %b want %b", valid, want.valid));
         if (index !== want.index)
            report_mismatch($sformatf("dispatch_index got %0d want %0d", index, want.index));
         if (mask !== want.mask)
            report_mismatch($sformatf("ready_mask got %b want %b", mask, want.mask));
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser  = '0;   // [1:0] operation
   logic [23:0] req_tdata  = '0;   // [2:0] task_slot, [18:3] period_ticks
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [0:0]  rsp_tuser;         // [0] dispatch_valid
   logic [15:0] rsp_tdata;         // [2:0] dispatch_index, [10:3] ready_mask

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int cycles       = 0;

   sched_scoreboard sb = new();

   periodic_task_scheduler_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("cycle limit of %0d reached, %0d responses outstanding",
                  CYCLE_LIMIT, sb.pending_results.size());
         $display("periodic_task_scheduler_top test failed");
         $finish;
      end
   end

   // Monitor both channels on the same edge the handshakes complete
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(op_type'(req_tuser), req_tdata[2:0], req_tdata[18:3]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tuser[0], rsp_tdata[2:0], rsp_tdata[10:3]);
      end
   end

   // Response backpressure in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_idle_pct > 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Drive one request transaction, with an optional idle burst ahead of it
   task automatic send_req(input op_type op, input logic [SLOT_W-1:0] slot,
                           input logic [PERIOD_W-1:0] per);
      int gap;
      gap = 0;
      if (req_idle_pct > 0 && $urandom_range(0, 99) < req_idle_pct)
         gap = $urandom_range(1, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'd0, per, slot};
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   // Random traffic: mostly small periods so tasks expire and get dispatched often
   task automatic run_random(input int count, input int req_pct, input int rsp_pct);
      int                  pick;
      int                  sel;
      logic [SLOT_W-1:0]   slot;
      logic [PERIOD_W-1:0] per;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         slot = SLOT_W'($urandom_range(0, TASK_SLOTS - 1));
         per  = PERIOD_W'($urandom_range(0, 65535));
         if (pick < 16) begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
               per = '0;
            else if (sel > 1)
               per = PERIOD_W'($urandom_range(1, 8));
            send_req(OP_CREATE, slot, per);
         end else if (pick < 22) begin
            send_req(OP_DELETE, slot, per);
         end else if (pick < 60) begin
            send_req(OP_TICK, slot, per);
         end else begin
            send_req(OP_DISPATCH, slot, per);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, period extremes, priority order, overrun, deletes
      send_req(OP_DISPATCH, 3'd0, 16'h0000);
      send_req(OP_TICK,     3'd0, 16'h0000);
      send_req(OP_DELETE,   3'd4, 16'h0000);
      send_req(OP_CREATE,   3'd0, 16'h0000);
      send_req(OP_CREATE,   3'd7, 16'hFFFF);
      send_req(OP_CREATE,   3'd3, 16'h5555);
      send_req(OP_CREATE,   3'd4, 16'hAAAA);
      send_req(OP_CREATE,   3'd5, 16'd2);
      send_req(OP_DISPATCH, 3'd0, 16'h0000);
      send_req(OP_DISPATCH, 3'd0, 16'h0000);
      send_req(OP_DISPATCH, 3'd0, 16'h0000);
      send_req(OP_DISPATCH, 3'd0, 16'h0000);
      send_req(OP_DISPATCH, 3'd0, 16'h0000);
      send_req(OP_DISPATCH, 3'd0, 16'h0000);
      send_req(OP_TICK,     3'd7, 16'hFFFF);
      send_req(OP_TICK,     3'd0, 16'h0000);
      send_req(OP_TICK,     3'd0, 16'h0000);
      send_req(OP_DELETE,   3'd7, 16'hFFFF);
      send_req(OP_DELETE,   3'd0, 16'h0000);
      send_req(OP_DISPATCH, 3'd0, 16'h0000);
      send_req(OP_CREATE,   3'd6, 16'd1);
      send_req(OP_DISPATCH, 3'd7, 16'hFFFF);
      send_req(OP_DELETE,   3'd5, 16'h0000);

      // Random: idling on both sides, then heavy backpressure, then none
      run_random(450, 30, 30);
      run_random(400, 10, 50);
      run_random(250, 0, 0);
      req_tvalid <= 1'b0;

      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending_results.size() != 0)
         sb.report_mismatch("expected responses never arrived");

      $display("ran %0d creates, %0d deletes, %0d ticks, %0d dispatch requests",
               sb.op_count[int'(OP_CREATE)], sb.op_count[int'(OP_DELETE)],
               sb.op_count[int'(OP_TICK)], sb.op_count[int'(OP_DISPATCH)]);
      $display("%0d responses checked, %0d dispatches found a ready task, %0d mismatches",
               sb.responses, sb.hits, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("periodic_task_scheduler_top test passed");
      end else begin
         $display("periodic_task_scheduler_top test failed");
      end
      $finish;
   end

endmodule

### periodic_task_scheduler_top.f
hdl/pts_pkg.sv
hdl/pts_slot.sv
hdl/pts_pick.sv
hdl/periodic_task_scheduler_top.sv
bench/tb_top.sv
